FILE: rtl/core/srp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg: shared constants and functions
// Operation codes, counter indexes and table outcome codes for the store
// range profiler.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam logic [2:0] OP_BEGIN = 3'd0;
  localparam logic [2:0] OP_END   = 3'd1;
  localparam logic [2:0] OP_STORE = 3'd2;
  localparam logic [2:0] OP_RDCNT = 3'd3;
  localparam logic [2:0] OP_RDENT = 3'd4;

  localparam logic [1:0] OUT_NONE  = 2'd0;
  localparam logic [1:0] OUT_MATCH = 2'd1;
  localparam logic [1:0] OUT_NEW   = 2'd2;
  localparam logic [1:0] OUT_OVF   = 2'd3;

  localparam logic [3:0] CNT_LOCK   = 4'd0;
  localparam logic [3:0] CNT_DONE   = 4'd1;
  localparam logic [3:0] CNT_BAD    = 4'd2;
  localparam logic [3:0] CNT_CALLS  = 4'd3;
  localparam logic [3:0] CNT_DEC    = 4'd4;
  localparam logic [3:0] CNT_DECOPN = 4'd5;
  localparam logic [3:0] CNT_OVLP   = 4'd6;
  localparam logic [3:0] CNT_SAMP   = 4'd7;
  localparam logic [3:0] CNT_OVFS   = 4'd8;
  localparam logic [3:0] CNT_BYTES  = 4'd9;
  localparam logic [3:0] CNT_OVFB   = 4'd10;
  localparam logic [3:0] CNT_MAX    = 4'd11;
  localparam logic [3:0] CNT_EN     = 4'd12;
  localparam logic [3:0] CNT_BASE   = 4'd13;
  localparam logic [3:0] CNT_LEN    = 4'd14;

  localparam int NUM_EVENTS = 9;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // Saturating adds
  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == MAX32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    sat_add48 = s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

FILE: rtl/core/srp_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_slot_table: per-PC source table
// Registered slots with a one-slot-per-cycle scan for a pc match and the
// lowest free slot, then an update step.
// ----------------------------------------------------------------------------
module srp_slot_table
  import srp_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,      // begin a sample insertion
  input  logic [31:0] pc,
  input  logic [31:0] ov,
  output logic        done,       // one-cycle pulse with outcome
  output logic [1:0]  outcome,
  input  logic [3:0]  rd_idx,
  output logic        rd_used,
  output logic [31:0] rd_pc,
  output logic [31:0] rd_samples,
  output logic [47:0] rd_bytes,
  output logic [31:0] rd_max
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [1:0] {T_IDLE, T_SCAN, T_UPD} tstate_t;

  tstate_t     st_r;
  logic [CW-1:0] ptr_r;
  logic          hit_r, free_ok_r;
  logic [IW-1:0] hit_idx_r, free_idx_r;
  logic [31:0] s_pc_r      [TABLE_SLOTS];
  logic [31:0] s_samples_r [TABLE_SLOTS];
  logic [47:0] s_bytes_r   [TABLE_SLOTS];
  logic [31:0] s_max_r     [TABLE_SLOTS];

  logic [IW-1:0] p;
  logic [IW-1:0] ri;
  logic          rin;
  assign p   = ptr_r[IW-1:0];
  assign rin = ({28'd0, rd_idx} < 32'(TABLE_SLOTS));
  assign ri  = IW'(rd_idx);

  always_comb begin
    rd_used = 1'b0; rd_pc = '0; rd_samples = '0; rd_bytes = '0; rd_max = '0;
    if (rin && s_samples_r[ri] != 32'd0) begin
      rd_used    = 1'b1;
      rd_pc      = s_pc_r[ri];
      rd_samples = s_samples_r[ri];
      rd_bytes   = s_bytes_r[ri];
      rd_max     = s_max_r[ri];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE;
      done <= 1'b0;
      outcome <= OUT_NONE;
      ptr_r <= '0;
      hit_r <= 1'b0;
      free_ok_r <= 1'b0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        s_pc_r[i] <= '0; s_samples_r[i] <= '0; s_bytes_r[i] <= '0; s_max_r[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (st_r)
        T_IDLE: begin
          if (start) begin
            ptr_r <= '0; hit_r <= 1'b0; free_ok_r <= 1'b0;
            st_r <= T_SCAN;
          end
        end
        T_SCAN: begin
          if (s_samples_r[p] == 32'd0) begin
            if (!free_ok_r) begin
              free_ok_r <= 1'b1; free_idx_r <= p;
            end
          end else if (s_pc_r[p] == pc) begin
            hit_r <= 1'b1; hit_idx_r <= p;
            st_r <= T_UPD;
          end
          if (ptr_r == CW'(TABLE_SLOTS - 1)) st_r <= T_UPD;
          ptr_r <= ptr_r + 1'b1;
        end
        T_UPD: begin
          done <= 1'b1;
          st_r <= T_IDLE;
          if (hit_r) begin
            s_samples_r[hit_idx_r] <= sat_inc32(s_samples_r[hit_idx_r]);
            s_bytes_r[hit_idx_r]   <= sat_add48(s_bytes_r[hit_idx_r], ov);
            if (ov > s_max_r[hit_idx_r]) s_max_r[hit_idx_r] <= ov;
            outcome <= OUT_MATCH;
          end else if (free_ok_r) begin
            s_pc_r[free_idx_r]      <= pc;
            s_samples_r[free_idx_r] <= 32'd1;
            s_bytes_r[free_idx_r]   <= {16'd0, ov};
            s_max_r[free_idx_r]     <= ov;
            outcome <= OUT_NEW;
          end else begin
            outcome <= OUT_OVF;
          end
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  a_done_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(st_r) == T_UPD) else $error("done without update");
  a_outcome_set: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> outcome != OUT_NONE) else $error("no outcome");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == T_IDLE) else $error("start while busy");

endmodule

FILE: rtl/core/store_range_profiler_with_source_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_range_profiler_with_source_table: store window profiler
// Counts stores against a watched window and samples overlapping stores
// into a per-PC source table.
// ----------------------------------------------------------------------------
// One transaction at a time. Begin, end and read transactions pass through
// S_EXEC to S_OUT; a store that reaches the overlap path goes through S_OV1
// and S_OV2, and a sampled store adds the table scan in S_TBL (one slot per
// cycle). in_tready is low while an item is in work or its result waits on
// out_tready.
module store_range_profiler_with_source_table
  import srp_pkg::*;
#(
  parameter int TABLE_SLOTS   = 16,
  parameter int SAMPLE_STRIDE = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // op[2:0], decoded, pc, address, nbytes, index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [231:0] out_tdata   // overlap_bytes, sampled, table_outcome[1:0],
                                   // window_active, read_value[47:0], entry_used,
                                   // entry_pc, entry_samples, entry_bytes[47:0],
                                   // entry_max
);

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_OV1, S_OV2, S_TBL, S_OUT} state_t;

  localparam int PW = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  // once the overlap count sticks at its maximum the sample decision is fixed
  localparam logic SAT_TAKE = ((64'hFFFF_FFFF % SAMPLE_STRIDE) == 0);

  state_t      st_r;
  logic [2:0]  op_r;
  logic        dec_r;
  logic [31:0] pc_r, addr_r, len_r;
  logic [3:0]  idx_r;
  logic        en_r, open_r;
  logic [31:0] base_r, wlen_r, maxov_r;
  logic [31:0] ev_r [NUM_EVENTS];
  logic [47:0] bt0_r, bt1_r;
  logic [32:0] ob_r, oe_r;
  logic [31:0] ov_r;
  logic        take_r;
  logic [PW-1:0] phase_r;
  logic [31:0] res_ov_r;
  logic        res_samp_r;
  logic [1:0]  res_out_r;
  logic [47:0] res_rd_r;
  logic        res_eu_r;
  logic [31:0] res_epc_r, res_es_r, res_em_r;
  logic [47:0] res_eb_r;

  logic        t_done;
  logic [1:0]  t_outcome;
  logic        t_used;
  logic [31:0] t_pc, t_samples, t_max;
  logic [47:0] t_bytes;
  logic        t_start;

  assign t_start = (st_r == S_OV2) && (ob_r < oe_r) && take_r;

  srp_slot_table #(.TABLE_SLOTS(TABLE_SLOTS)) u_tbl (
    .clk, .rst_n, .start(t_start), .pc(pc_r), .ov(32'(oe_r - ob_r)),
    .done(t_done), .outcome(t_outcome), .rd_idx(idx_r), .rd_used(t_used),
    .rd_pc(t_pc), .rd_samples(t_samples), .rd_bytes(t_bytes), .rd_max(t_max)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = {3'b0, res_em_r, res_eb_r, res_es_r, res_epc_r, res_eu_r,
                       res_rd_r, open_r, res_out_r, res_samp_r, res_ov_r};

  logic [32:0] wend;
  logic [32:0] send;
  assign wend = {1'b0, base_r} + {1'b0, wlen_r};
  assign send = {1'b0, addr_r} + {1'b0, len_r};

  // phase_r tracks the overlap count modulo the stride until the count saturates
  logic stride_hit;
  assign stride_hit = (ev_r[CNT_OVLP] == MAX32) ? SAT_TAKE : (phase_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      en_r <= 1'b0; open_r <= 1'b0; base_r <= '0; wlen_r <= '0; maxov_r <= '0;
      bt0_r <= '0; bt1_r <= '0;
      phase_r <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) ev_r[i] <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r <= in_tdata[2:0]; dec_r <= in_tdata[3]; pc_r <= in_tdata[35:4];
            addr_r <= in_tdata[67:36]; len_r <= in_tdata[99:68];
            idx_r <= in_tdata[103:100];
            res_ov_r <= '0; res_samp_r <= 1'b0; res_out_r <= OUT_NONE;
            res_rd_r <= '0; res_eu_r <= 1'b0; res_epc_r <= '0; res_es_r <= '0;
            res_eb_r <= '0; res_em_r <= '0;
            st_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_r <= S_OUT;
          case (op_r)
            OP_BEGIN: begin
              en_r <= 1'b1;
              ev_r[CNT_LOCK] <= sat_inc32(ev_r[CNT_LOCK]);
              if (addr_r == 0 || len_r == 0 || send > 33'h1_0000_0000) begin
                ev_r[CNT_BAD] <= sat_inc32(ev_r[CNT_BAD]);
                open_r <= 1'b0; base_r <= '0; wlen_r <= '0;
              end else begin
                open_r <= 1'b1; base_r <= addr_r; wlen_r <= len_r;
              end
            end
            OP_END: begin
              if (open_r) begin
                ev_r[CNT_DONE] <= sat_inc32(ev_r[CNT_DONE]);
                open_r <= 1'b0; base_r <= '0; wlen_r <= '0;
              end
            end
            OP_STORE: begin
              if (en_r) begin
                ev_r[CNT_CALLS] <= sat_inc32(ev_r[CNT_CALLS]);
                if (dec_r) begin
                  ev_r[CNT_DEC] <= sat_inc32(ev_r[CNT_DEC]);
                  if (open_r) begin
                    ev_r[CNT_DECOPN] <= sat_inc32(ev_r[CNT_DECOPN]);
                    if (len_r != 0) st_r <= S_OV1;
                  end
                end
              end
            end
            OP_RDCNT: begin
              case (idx_r)
                CNT_BYTES: res_rd_r <= bt0_r;
                CNT_OVFB:  res_rd_r <= bt1_r;
                CNT_MAX:   res_rd_r <= {16'd0, maxov_r};
                CNT_EN:    res_rd_r <= {47'd0, en_r};
                CNT_BASE:  res_rd_r <= {16'd0, base_r};
                CNT_LEN:   res_rd_r <= {16'd0, wlen_r};
                default:   res_rd_r <= (idx_r <= CNT_OVFS) ? {16'd0, ev_r[idx_r]} : '0;
              endcase
            end
            OP_RDENT: begin
              res_eu_r <= t_used; res_epc_r <= t_pc; res_es_r <= t_samples;
              res_eb_r <= t_bytes; res_em_r <= t_max;
            end
            default: ;
          endcase
        end
        S_OV1: begin
          // overlap bounds
          ob_r <= ({1'b0, addr_r} > {1'b0, base_r}) ? {1'b0, addr_r} : {1'b0, base_r};
          oe_r <= (send < wend) ? send : wend;
          take_r <= stride_hit;
          st_r <= S_OV2;
        end
        S_OV2: begin
          st_r <= S_OUT;
          if (ob_r < oe_r) begin
            ov_r <= 32'(oe_r - ob_r);
            res_ov_r <= 32'(oe_r - ob_r);
            ev_r[CNT_OVLP] <= sat_inc32(ev_r[CNT_OVLP]);
            phase_r <= (phase_r == PW'(SAMPLE_STRIDE - 1)) ? '0 : phase_r + 1'b1;
            bt0_r <= sat_add48(bt0_r, 32'(oe_r - ob_r));
            if (32'(oe_r - ob_r) > maxov_r) maxov_r <= 32'(oe_r - ob_r);
            if (take_r) begin
              ev_r[CNT_SAMP] <= sat_inc32(ev_r[CNT_SAMP]);
              res_samp_r <= 1'b1;
              st_r <= S_TBL;
            end
          end
        end
        S_TBL: begin
          if (t_done) begin
            res_out_r <= t_outcome;
            if (t_outcome == OUT_OVF) begin
              ev_r[CNT_OVFS] <= sat_inc32(ev_r[CNT_OVFS]);
              bt1_r <= sat_add48(bt1_r, ov_r);
            end
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_tready) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_no_overlap_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_samp_r |-> res_out_r == OUT_NONE) else $error("outcome w/o sample");
  a_open_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> wlen_r != 0 && base_r != 0) else $error("bad open window");
  a_open_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> en_r) else $error("open while disabled");

endmodule
